// File: rtl/nac_pkg.sv
// Shared types, constants and helpers for the colour address finder.
// Depends on nothing; imported by next_allowed_color_address_top, nac_result_checker and tb.
package nac_pkg;

  // Build-time sizes
  localparam int TABLE_DEPTH = 64;
  localparam int PAGE_BITS  = 12;
  localparam int ADDR_BITS  = 48;

  // Field widths
  localparam int ADDR_W  = 48;
  localparam int COLOR_W = 6;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int CB_W    = 3;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Widest colour field supported
  localparam logic [CB_W-1:0] CB_MAX = CB_W'(COLOR_W);

  // Address mask at ADDR_BITS, limited to the port width
  localparam logic [63:0] ADDR_MASK64 =
    (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_MASK64[ADDR_W-1:0];

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_BITS  = 1'b0,
    CFG_COLOR_COUNT = 1'b1
  } cfg_reg_t;

  // Request codes
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SAME   = 2'd1,
    KIND_HIGHER = 2'd2,
    KIND_NEXT   = 2'd3
  } kind_t;

  // Replace the colour field above the page offset
  function automatic logic [ADDR_W-1:0] set_color(input logic [ADDR_W-1:0]  addr,
                                                  input logic [COLOR_W-1:0] cmask,
                                                  input logic [COLOR_W-1:0] c);
    logic [ADDR_W-1:0] field;
    logic [ADDR_W-1:0] ins;
    field = ADDR_W'(cmask) << PAGE_BITS;
    ins   = ADDR_W'(c & cmask) << PAGE_BITS;
    return ((addr & ~field) | ins) & ADDR_MASK;
  endfunction

endpackage

// File: rtl/next_allowed_color_address_top.sv
// A table write passes from ST_IDLE through ST_DONE to the output register; a
// query also passes through ST_WALK, where it stops at table entry k (counting
// from 1) or walks all n entries (n = color_count, max 64) without a stop.
// One item is in work at a time; the walk reads one table entry per cycle
// from the registered read port of the colour memory.
// The next item is taken while a finished beat still waits at the output.
// Reset (synchronous, rst_n low): table reads as all zeros through per-entry
// valid bits, color_bits = 0, color_count = 1, both channels empty.
module next_allowed_color_address_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [nac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nac_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [nac_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [nac_pkg::COLOR_W-1:0]   in_entry_color,
  input  logic [nac_pkg::ADDR_W-1:0]    in_phys_addr,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nac_pkg::ADDR_W-1:0]    out_next_addr,
  output logic [nac_pkg::KIND_W-1:0]    out_result_kind
);
  import nac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;

  logic [CB_W-1:0]    color_bits_r;
  logic [CNT_W-1:0]   color_count_r;

  logic [COLOR_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_valid_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [COLOR_W-1:0] entry0_r;

  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  kind_t              res_kind_r, res_kind_nxt;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  kind_t              out_kind_r;

  logic               in_acc;
  logic               wr_en;
  logic               out_free;
  logic [CB_W-1:0]    cb;
  logic [COLOR_W-1:0] cmask;
  logic [COLOR_W-1:0] entry;
  logic [ADDR_W-1:0]  wrap_addr;

  // Effective colour width and mask
  assign cb    = (color_bits_r > CB_MAX) ? CB_MAX : color_bits_r;
  assign cmask = COLOR_W'((7'd1 << cb) - 7'd1);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_req_type == REQ_WRITE) &&
                    (CNT_W'(in_entry_index) < CNT_W'(TABLE_DEPTH));
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_bits_r  <= '0;
      color_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_BITS:  color_bits_r  <= cfg_wdata[CB_W-1:0];
        CFG_COLOR_COUNT: color_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read entry 0 when a query enters, then the entry after the one compared
  assign rd_addr = (state_r == ST_IDLE) ? '0 : IDX_W'(idx_r[IDX_W-1:0] + IDX_W'(1));

  // Colour table: write on accepted writes, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_entry_index] <= in_entry_color & cmask;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Per-entry valid bits and a copy of entry 0 for the wrap case
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      entry0_r   <= '0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[in_entry_index] <= 1'b1;
        if (in_entry_index == '0) begin
          entry0_r <= in_entry_color & cmask;
        end
      end
    end
  end

  assign entry     = rd_valid_r ? rd_data_r : '0;
  assign wrap_addr = (addr_r + (ADDR_W'(1) << (PAGE_BITS + int'(cb)))) & ADDR_MASK;

  // Walk sequencer
  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    color_nxt    = color_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    res_addr_nxt = res_addr_r;
    res_kind_nxt = res_kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_WRITE) begin
            res_addr_nxt = '0;
            res_kind_nxt = KIND_WRITE;
            state_nxt    = ST_DONE;
          end else begin
            addr_nxt  = in_phys_addr & ADDR_MASK;
            color_nxt = COLOR_W'((in_phys_addr & ADDR_MASK) >> PAGE_BITS) & cmask;
            n_nxt     = (color_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : color_count_r;
            idx_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (idx_r < n_r) begin
          priority if (color_r == entry) begin
            res_addr_nxt = addr_r;
            res_kind_nxt = KIND_SAME;
            state_nxt    = ST_DONE;
          end else if (color_r < entry) begin
            res_addr_nxt = set_color(addr_r, cmask, entry);
            res_kind_nxt = KIND_HIGHER;
            state_nxt    = ST_DONE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else begin
          res_addr_nxt = set_color(wrap_addr, cmask, entry0_r);
          res_kind_nxt = KIND_NEXT;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    color_r    <= color_nxt;
    n_r        <= n_nxt;
    res_addr_r <= res_addr_nxt;
    res_kind_r <= res_kind_nxt;
  end

  // Output register: load the finished result when the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_addr_r <= res_addr_r;
      out_kind_r <= res_kind_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_addr   = out_addr_r;
  assign out_result_kind = out_kind_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (idx_r <= n_r))
    else $error("walk index beyond table count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted item did not start work");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_WRITE)) |-> (out_addr_r == '0))
    else $error("write beat carries a non-zero address");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

// File: tb/sv/nac_result_checker.sv
// Result checker for the colour address finder: predicts every beat and compares.
// Depends on nac_pkg; instantiated by tb beside next_allowed_color_address_top.
`timescale 1ns / 1ps

module nac_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nac_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [nac_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [nac_pkg::COLOR_W-1:0]   in_entry_color,
  input  logic [nac_pkg::ADDR_W-1:0]    in_phys_addr,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [nac_pkg::ADDR_W-1:0]    out_next_addr,
  input  logic [nac_pkg::KIND_W-1:0]    out_result_kind,
  output int                            n_fail,
  output int                            n_pending,
  output int                            n_beats
);
  import nac_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    kind_t             kind;
  } colour_result_t;

  // Own copy of the block state
  logic [COLOR_W-1:0] colour_tbl [TABLE_DEPTH];
  logic [CB_W-1:0]    cb_reg;
  logic [CNT_W-1:0]   cnt_reg;

  colour_result_t     awaited_q [$];
  colour_result_t     want;
  int                 k;

  // Colour mask for the current width, clamped at six bits
  function automatic logic [COLOR_W-1:0] colour_mask();
    logic [CB_W-1:0] cb;
    cb = (cb_reg > CB_W'(6)) ? CB_W'(6) : cb_reg;
    return COLOR_W'((7'd1 << cb) - 7'd1);
  endfunction

  // Replace the colour field of an address
  function automatic logic [ADDR_W-1:0] put_colour(input logic [ADDR_W-1:0]  a,
                                                   input logic [COLOR_W-1:0] m,
                                                   input logic [COLOR_W-1:0] c);
    return (a & ~(ADDR_W'(m) << PAGE_BITS)) | (ADDR_W'(c & m) << PAGE_BITS);
  endfunction

  // Walk the table and work out the next allowed address
  function automatic colour_result_t find_next_addr(input logic [ADDR_W-1:0] pa);
    logic [CB_W-1:0]    cb;
    logic [COLOR_W-1:0] m;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] e;
    logic [ADDR_W-1:0]  a;
    colour_result_t     r;
    int                 n;
    int                 i;
    bit                 hit;
    cb  = (cb_reg > CB_W'(6)) ? CB_W'(6) : cb_reg;
    m   = colour_mask();
    a   = pa & ADDR_MASK;
    c   = COLOR_W'(a >> PAGE_BITS) & m;
    n   = (cnt_reg > CNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(cnt_reg);
    hit = 1'b0;
    r   = '0;
    for (i = 0; i < n && !hit; i++) begin
      e = colour_tbl[i];
      if (c == e) begin
        r.addr = a;
        r.kind = KIND_SAME;
        hit    = 1'b1;
      end else if (c < e) begin
        r.addr = put_colour(a, m, e);
        r.kind = KIND_HIGHER;
        hit    = 1'b1;
      end
    end
    // No entry at or above: step one way size and take entry 0
    if (!hit) begin
      a      = (a + (ADDR_W'(1) << (PAGE_BITS + cb))) & ADDR_MASK;
      r.addr = put_colour(a, m, colour_tbl[0]);
      r.kind = KIND_NEXT;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] exp_v,
                                 input logic [ADDR_W-1:0] got_v);
    if (n_fail < 40)
      $display("  mismatch at %0t: %s, expected %h, got %h", $realtime, what, exp_v, got_v);
    n_fail++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < TABLE_DEPTH; k++) colour_tbl[k] = '0;
      cb_reg  = '0;
      cnt_reg = CNT_W'(1);
      awaited_q.delete();
    end else begin
      // Retire the result beat first: it can only belong to an earlier item
      if (out_valid && !out_stall) begin
        n_beats++;
        if (awaited_q.size() == 0) begin
          report_mismatch("result beat with nothing awaited", '0, out_next_addr);
        end else begin
          want = awaited_q.pop_front();
          if (out_next_addr !== want.addr)
            report_mismatch("next_addr", want.addr, out_next_addr);
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", ADDR_W'(want.kind), ADDR_W'(out_result_kind));
        end
      end
      // Register writes
      if (cfg_we) begin
        if (cfg_index == CFG_COLOR_BITS) cb_reg = cfg_wdata[CB_W-1:0];
        else                             cnt_reg = cfg_wdata[CNT_W-1:0];
      end
      // Predict the accepted input beat
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_WRITE) begin
          colour_tbl[in_entry_index] = in_entry_color & colour_mask();
          want.addr = '0;
          want.kind = KIND_WRITE;
          awaited_q.push_back(want);
        end else begin
          awaited_q.push_back(find_next_addr(in_phys_addr));
        end
      end
    end
    n_pending = awaited_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for next_allowed_color_address_top: clock, reset, stimulus, verdict.
// Depends on nac_pkg, the block and nac_result_checker, which does all the checking.
`timescale 1ns / 1ps

module tb;
  import nac_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RAND_ITEMS   = 1750;
  localparam int HOLD_PHASE   = 3;
  localparam int QUIET_PHASE  = 5;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_req_type     = 1'b0;
  logic [IDX_W-1:0]     in_entry_index  = '0;
  logic [COLOR_W-1:0]   in_entry_color  = '0;
  logic [ADDR_W-1:0]    in_phys_addr    = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [ADDR_W-1:0]    out_next_addr;
  logic [KIND_W-1:0]    out_result_kind;

  int n_fail;
  int n_pending;
  int n_beats;

  int cycles      = 0;
  int idle_pct    = 33;
  int phase_no    = 0;
  int hold_left   = 0;
  bit held        = 1'b0;
  int n_writes    = 0;
  int n_queries   = 0;
  int n_settings  = 0;
  int cur_mask    = 0;
  int shadow [TABLE_DEPTH];

  next_allowed_color_address_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .in_phys_addr    (in_phys_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_addr   (out_next_addr),
    .out_result_kind (out_result_kind)
  );

  nac_result_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .in_phys_addr    (in_phys_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_addr   (out_next_addr),
    .out_result_kind (out_result_kind),
    .n_fail          (n_fail),
    .n_pending       (n_pending),
    .n_beats         (n_beats)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, n_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (!held && phase_no == HOLD_PHASE) begin
        held      = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Put colour c into the address colour field under mask m
  function automatic logic [ADDR_W-1:0] place_colour(input logic [ADDR_W-1:0] a,
                                                     input int c, input int m);
    logic [COLOR_W-1:0] f;
    f = a[PAGE_BITS +: COLOR_W];
    a[PAGE_BITS +: COLOR_W] = (f & ~COLOR_W'(m)) | (COLOR_W'(c) & COLOR_W'(m));
    return a;
  endfunction

  // Offer one input beat, after an optional random gap, and hold it until taken
  task automatic offer_beat(input req_t rt, input int idx, input int col,
                            input logic [ADDR_W-1:0] pa);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_entry_index <= IDX_W'(idx);
    in_entry_color <= COLOR_W'(col);
    in_phys_addr   <= pa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_entry(input int idx, input int col);
    shadow[idx % TABLE_DEPTH] = col & cur_mask;
    n_writes++;
    offer_beat(REQ_WRITE, idx, col, rand_addr());
  endtask

  task automatic ask_addr(input logic [ADDR_W-1:0] pa);
    n_queries++;
    offer_beat(REQ_QUERY, $urandom_range(63), $urandom_range(63), pa);
  endtask

  // Drain the block, then write both registers back to back
  task automatic set_colour_cfg(input int cb, input int cnt);
    int eff;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLOR_BITS;
    cfg_wdata <= CFG_W'(cb);
    @(posedge clk);
    cfg_index <= CFG_COLOR_COUNT;
    cfg_wdata <= CFG_W'(cnt);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff      = (cb > 6) ? 6 : cb;
    cur_mask = (1 << eff) - 1;
    n_settings++;
  endtask

  initial begin
    int cb;
    int cnt;
    int n;
    int q;
    int r;
    int i;
    int tgt;
    int cols [];

    foreach (shadow[j]) shadow[j] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, one colour, every query lands on entry 0
    ask_addr('0);
    ask_addr({ADDR_W{1'b1}});
    push_entry(5, 63);

    // Full width, full table, hand-built ascending entries
    set_colour_cfg(6, 64);
    push_entry(0, 5);
    push_entry(1, 20);
    push_entry(2, 63);
    push_entry(63, 0);
    push_entry(63, 63);
    ask_addr(place_colour(rand_addr(), 5, 63));
    ask_addr(place_colour(rand_addr(), 3, 63));
    ask_addr(place_colour(rand_addr(), 10, 63));
    ask_addr(place_colour(rand_addr(), 62, 63));
    ask_addr({ADDR_W{1'b1}});

    // Short table: colours above every walked entry step into the next span and wrap
    set_colour_cfg(6, 2);
    ask_addr({ADDR_W{1'b1}});
    ask_addr(place_colour(rand_addr(), 30, 63));

    // Empty table
    set_colour_cfg(6, 0);
    ask_addr(rand_addr());

    // Width and count beyond range are clamped
    set_colour_cfg(7, 127);
    ask_addr(place_colour(rand_addr(), 63, 63));
    ask_addr(place_colour('0, 0, 63));

    // Stale entries under a narrower width
    set_colour_cfg(2, 1);
    ask_addr(place_colour(rand_addr(), 1, 3));
    ask_addr(place_colour(rand_addr(), 3, 3));

    // Zero width masks every written colour away
    set_colour_cfg(0, 1);
    push_entry(0, 63);
    ask_addr({ADDR_W{1'b1}});

    // Random phases: mostly an ascending table followed by aimed queries
    while (n_writes + n_queries < RAND_ITEMS + 25) begin
      phase_no++;
      idle_pct = (phase_no == QUIET_PHASE) ? 0 : 33;
      r  = $urandom_range(9);
      cb = (r == 0) ? 0 : (r == 1) ? 6 : (r == 2) ? 7 : $urandom_range(7);
      r  = $urandom_range(9);
      case (r)
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 64;
        3:       cnt = 127;
        4, 5, 6: cnt = $urandom_range(1, 8);
        default: cnt = $urandom_range(1, 64);
      endcase
      set_colour_cfg(cb, cnt);
      n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
      if (n > 0 && $urandom_range(3) == 0) n = $urandom_range(1, n);

      r = $urandom_range(9);
      if (r < 7) begin
        // Ascending colours, with garbage above the mask to be dropped on write
        cols = new[n];
        foreach (cols[j]) cols[j] = $urandom_range(cur_mask);
        cols.sort();
        for (i = 0; i < n; i++)
          push_entry(i, cols[i] | ($urandom_range(63) & ~cur_mask));
      end else if (r == 7) begin
        for (i = 0; i < n; i++) push_entry(i, $urandom_range(63));
      end
      // Otherwise keep the table as it stands, stale entries and all

      q = $urandom_range(8, 30);
      for (i = 0; i < q; i++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          push_entry($urandom_range(63), $urandom_range(63));
        end else if (r < 15) begin
          ask_addr(rand_addr());
        end else begin
          case ($urandom_range(5))
            0:       tgt = 0;
            1:       tgt = cur_mask;
            default: tgt = shadow[$urandom_range((n > 0) ? n - 1 : 0)]
                           + $urandom_range(2) - 1;
          endcase
          ask_addr(place_colour(rand_addr(), tgt, cur_mask));
        end
      end
    end

    // Drain and let any stray beat show itself
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Covered %0d table writes and %0d queries over %0d colour settings,",
             n_writes, n_queries, n_settings);
    $display("with clamped widths and counts, stale entries and a long output hold-off.");
    if (n_fail == 0 && n_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches over %0d result beats", n_fail, n_beats);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
